FILE: src/cmid_pkg.sv
// Shared types, constants and helpers for the cross mean image difference block.
// Used by every module under src but cmid_line_store; has no dependencies of its own.
`default_nettype none

package cmid_pkg;

  localparam int unsigned MaxWidthDefault  = 1024;
  localparam int unsigned MaxHeightDefault = 1024;

  localparam int unsigned PixW    = 8;
  localparam int unsigned PairW   = 2 * PixW;
  localparam int unsigned PosW    = 10;
  localparam int unsigned SizeW   = 11;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned SumW    = 11;
  localparam int unsigned MinSize = 3;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_FRAME_WIDTH  = 2'd0,
    CFG_FRAME_HEIGHT = 2'd1
  } cfg_reg_t;

  // Position information that travels with a pixel from the raster tracker
  // to the window stage.
  typedef struct packed {
    logic            emit;
    logic            last;
    logic [PosW-1:0] out_col;
    logic [PosW-1:0] out_row;
  } pos_tag_t;

  // Truncated division by five for sums up to 5 * 255, done as a multiply
  // by 13108 / 2^16. The error stays below 1/50 over that range.
  function automatic logic [PixW-1:0] div5(input logic [SumW-1:0] s);
    logic [SumW+14:0] p;
    p = (SumW+15)'(s) * (SumW+15)'(13108);
    return p[PixW+15:16];
  endfunction

endpackage

`default_nettype wire

FILE: src/cmid_line_store.sv
// Row store memory: one entry per column, holding the previous row and the
// row before it for both images. Uses no package items.
`default_nettype none

module cmid_line_store #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned DW    = 32
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [DW-1:0]            wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [DW-1:0]            rd_data
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

FILE: src/cmid_raster.sv
// Raster position tracker: clamps the frame size and counts column and row.
// Depends on cmid_pkg for the position tag type and size constants.
`default_nettype none

module cmid_raster #(
  parameter int unsigned MAX_WIDTH  = cmid_pkg::MaxWidthDefault,
  parameter int unsigned MAX_HEIGHT = cmid_pkg::MaxHeightDefault
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          advance,
  input  wire logic [cmid_pkg::SizeW-1:0]    frame_width,
  input  wire logic [cmid_pkg::SizeW-1:0]    frame_height,
  output logic      [$clog2(MAX_WIDTH)-1:0]  cur_col,
  output cmid_pkg::pos_tag_t                 cur_tag
);

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned RW = $clog2(MAX_HEIGHT);
  localparam int unsigned WW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HW = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned LWW = (WW > cmid_pkg::SizeW) ? WW : cmid_pkg::SizeW;
  localparam int unsigned LHW = (HW > cmid_pkg::SizeW) ? HW : cmid_pkg::SizeW;

  logic [CW-1:0] col_cnt, col_cnt_next;
  logic [RW-1:0] row_cnt, row_cnt_next;

  logic [WW-1:0] w_eff;
  logic [HW-1:0] h_eff;
  logic [LWW-1:0] fw_ext;
  logic [LHW-1:0] fh_ext;

  logic [CW-1:0] c0;
  logic [RW-1:0] r0;
  logic [HW-1:0] row_inc;
  logic [HW-1:0] r0_inc;
  logic [WW-1:0] c0_inc;
  logic          pre_wrap;
  logic [31:0]   col_m1;
  logic [31:0]   row_m1;

  // Register values outside the supported range act as the nearest bound.
  always_comb begin
    fw_ext = LWW'(frame_width);
    fh_ext = LHW'(frame_height);
    if (fw_ext < LWW'(cmid_pkg::MinSize)) begin
      w_eff = WW'(cmid_pkg::MinSize);
    end else if (fw_ext > LWW'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = fw_ext[WW-1:0];
    end
    if (fh_ext < LHW'(cmid_pkg::MinSize)) begin
      h_eff = HW'(cmid_pkg::MinSize);
    end else if (fh_ext > LHW'(MAX_HEIGHT)) begin
      h_eff = HW'(MAX_HEIGHT);
    end else begin
      h_eff = fh_ext[HW-1:0];
    end
  end

  // A size reduced between frames can leave the counters past the new edge;
  // the position then wraps before the pixel is taken.
  always_comb begin
    pre_wrap = (WW'(col_cnt) >= w_eff);
    row_inc  = HW'(row_cnt) + HW'(1);
    c0       = pre_wrap ? '0 : col_cnt;
    if (pre_wrap) begin
      r0 = (row_inc >= h_eff) ? '0 : row_inc[RW-1:0];
    end else begin
      r0 = (HW'(row_cnt) >= h_eff) ? '0 : row_cnt;
    end
    c0_inc = WW'(c0) + WW'(1);
    r0_inc = HW'(r0) + HW'(1);
    if (c0_inc >= w_eff) begin
      col_cnt_next = '0;
      row_cnt_next = (r0_inc >= h_eff) ? '0 : r0_inc[RW-1:0];
    end else begin
      col_cnt_next = c0_inc[CW-1:0];
      row_cnt_next = r0;
    end
  end

  always_comb begin
    col_m1          = 32'(c0) - 32'd1;
    row_m1          = 32'(r0) - 32'd1;
    cur_col         = c0;
    cur_tag.emit    = (32'(c0) >= 32'd2) && (32'(r0) >= 32'd2);
    cur_tag.last    = (c0_inc == w_eff) && (r0_inc == h_eff);
    cur_tag.out_col = col_m1[cmid_pkg::PosW-1:0];
    cur_tag.out_row = row_m1[cmid_pkg::PosW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_cnt <= '0;
      row_cnt <= '0;
    end else if (advance) begin
      col_cnt <= col_cnt_next;
      row_cnt <= row_cnt_next;
    end
  end

endmodule

`default_nettype wire

FILE: src/cmid_window.sv
// Window stage: holds the accepted pixel pair, keeps the neighbor window,
// forms both five point means and the clamped difference into the result register.
// Depends on cmid_pkg for the position tag and the divide by five.
`default_nettype none

module cmid_window #(
  parameter int unsigned CW = 10
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [cmid_pkg::PixW-1:0]     test_pixel,
  input  wire logic [cmid_pkg::PixW-1:0]     reference_pixel,
  input  wire logic [CW-1:0]                 cur_col,
  input  wire cmid_pkg::pos_tag_t            cur_tag,
  input  wire logic [2*cmid_pkg::PairW-1:0]  rd_data,
  output logic                               wr_en,
  output logic      [CW-1:0]                 wr_addr,
  output logic      [2*cmid_pkg::PairW-1:0]  wr_data,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic      [cmid_pkg::PixW-1:0]     diff_pixel,
  output logic      [cmid_pkg::PosW-1:0]     out_col,
  output logic      [cmid_pkg::PosW-1:0]     out_row,
  output logic                               frame_done
);

  localparam int unsigned PW = cmid_pkg::PairW;
  localparam int unsigned XW = cmid_pkg::PixW;
  localparam int unsigned SW = cmid_pkg::SumW;

  logic               s1_valid;
  logic [PW-1:0]      s1_cur;
  logic [CW-1:0]      s1_col;
  cmid_pkg::pos_tag_t s1_tag;

  // Window slots: middle row at c-1 and c-2, top row at c-1, current row at c-1.
  logic [PW-1:0] mid1, mid2, top1, left;

  logic          out_free;
  logic          s1_adv;
  logic          in_accept;
  logic [PW-1:0] above, two;
  logic [SW-1:0] sum_t, sum_r;
  logic [XW-1:0] mean_t, mean_r;
  logic [XW-1:0] diff;

  assign out_free  = !out_valid || !out_stall;
  assign s1_adv    = s1_valid && out_free;
  assign in_stall  = s1_valid && !out_free;
  assign in_accept = in_valid && !in_stall;

  assign above = rd_data[2*PW-1:PW];
  assign two   = rd_data[PW-1:0];

  always_comb begin
    sum_t = SW'(top1[XW-1:0]) + SW'(mid2[XW-1:0]) + SW'(mid1[XW-1:0])
          + SW'(above[XW-1:0]) + SW'(left[XW-1:0]);
    sum_r = SW'(top1[PW-1:XW]) + SW'(mid2[PW-1:XW]) + SW'(mid1[PW-1:XW])
          + SW'(above[PW-1:XW]) + SW'(left[PW-1:XW]);
    mean_t = cmid_pkg::div5(sum_t);
    mean_r = cmid_pkg::div5(sum_r);
    diff   = (mean_t > mean_r) ? (mean_t - mean_r) : '0;
  end

  // The row stores shift by one row as the pixel leaves this stage.
  assign wr_en   = s1_adv;
  assign wr_addr = s1_col;
  assign wr_data = {s1_cur, above};

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_cur <= {reference_pixel, test_pixel};
      s1_col <= cur_col;
      s1_tag <= cur_tag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mid1 <= '0;
      mid2 <= '0;
      top1 <= '0;
      left <= '0;
    end else if (s1_adv) begin
      mid1 <= above;
      mid2 <= mid1;
      top1 <= two;
      left <= s1_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_adv && s1_tag.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_tag.emit) begin
      diff_pixel <= diff;
      out_col    <= s1_tag.out_col;
      out_row    <= s1_tag.out_row;
      frame_done <= s1_tag.last;
    end
  end

endmodule

`default_nettype wire

FILE: src/cross_mean_image_difference_top.sv
// Top level of the cross mean image difference block: configuration registers,
// raster tracker, row store memory and window stage.
// Depends on cmid_pkg, cmid_raster, cmid_line_store and cmid_window.
//
// Usage: test and reference pixels of the same position enter together on the
// input channel (in_valid / in_stall) in raster order. For every interior
// pixel one result leaves on the output channel (out_valid / out_stall) with
// the clamped difference of the two five point means, its column and row,
// and frame_done on the last interior pixel. Border pixels give no result.
// The result for centre (r-1, c-1) appears when pixel (r, c) has entered.
// The input register and the row store read load together when a pixel is
// accepted, and the result register loads when the window stage passes that
// pixel on. Throughput is one pixel per cycle while the receiver does not
// stall, with one row store read and one write per pixel. When the receiver
// stalls, the result register holds, the window stage takes at most one more
// pixel and in_stall stays high while that pixel waits. Frame size is written
// through cfg_valid / cfg_ready (always ready); the user writes it only while
// the block is idle, which the block itself does not enforce. Reset sets both
// sizes to 1024 and the position to the frame start; the row stores are not
// cleared and need no clearing pass; a frame's first two rows fill them.
`default_nettype none

module cross_mean_image_difference_top #(
  parameter int unsigned MAX_WIDTH  = cmid_pkg::MaxWidthDefault,
  parameter int unsigned MAX_HEIGHT = cmid_pkg::MaxHeightDefault
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [cmid_pkg::CfgIdxW-1:0] cfg_index,
  input  wire logic [cmid_pkg::SizeW-1:0]   cfg_data,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [cmid_pkg::PixW-1:0]    test_pixel,
  input  wire logic [cmid_pkg::PixW-1:0]    reference_pixel,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic      [cmid_pkg::PixW-1:0]    diff_pixel,
  output logic      [cmid_pkg::PosW-1:0]    out_col,
  output logic      [cmid_pkg::PosW-1:0]    out_row,
  output logic                              frame_done
);

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned DW = 2 * cmid_pkg::PairW;

  logic [cmid_pkg::SizeW-1:0] frame_width;
  logic [cmid_pkg::SizeW-1:0] frame_height;

  logic               in_accept;
  logic [CW-1:0]      cur_col;
  cmid_pkg::pos_tag_t cur_tag;
  logic               wr_en;
  logic [CW-1:0]      wr_addr;
  logic [DW-1:0]      wr_data;
  logic [DW-1:0]      rd_data;

  assign cfg_ready = 1'b1;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= cmid_pkg::SizeW'(1024);
      frame_height <= cmid_pkg::SizeW'(1024);
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == cmid_pkg::CFG_FRAME_WIDTH) begin
        frame_width <= cfg_data;
      end
      if (cfg_index == cmid_pkg::CFG_FRAME_HEIGHT) begin
        frame_height <= cfg_data;
      end
    end
  end

  cmid_raster #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_raster (
    .clk          (clk),
    .rst          (rst),
    .advance      (in_accept),
    .frame_width  (frame_width),
    .frame_height (frame_height),
    .cur_col      (cur_col),
    .cur_tag      (cur_tag)
  );

  cmid_line_store #(
    .DEPTH (MAX_WIDTH),
    .DW    (DW)
  ) u_line_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (in_accept),
    .rd_addr (cur_col),
    .rd_data (rd_data)
  );

  cmid_window #(
    .CW (CW)
  ) u_window (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .test_pixel      (test_pixel),
    .reference_pixel (reference_pixel),
    .cur_col         (cur_col),
    .cur_tag         (cur_tag),
    .rd_data         (rd_data),
    .wr_en           (wr_en),
    .wr_addr         (wr_addr),
    .wr_data         (wr_data),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .diff_pixel      (diff_pixel),
    .out_col         (out_col),
    .out_row         (out_row),
    .frame_done      (frame_done)
  );

endmodule

`default_nettype wire

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for cross_mean_image_difference_top: streams pixel pairs
// through the block and compares every difference result with its own prediction.
// Depends on cmid_pkg and the RTL under src; reads no files.

module testbench;
  import cmid_pkg::*;

  localparam int SettleCycles       = 6;
  localparam int ResultHoldCycles   = 300;
  localparam int RandomPixelTarget  = 1000;

  typedef struct packed {
    logic [PixW-1:0] diff;
    logic [PosW-1:0] col;
    logic [PosW-1:0] row;
    logic            done;
  } diff_result_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_valid;
  logic cfg_ready;
  logic [CfgIdxW-1:0] cfg_index;
  logic [SizeW-1:0] cfg_data;
  logic in_valid;
  logic in_stall;
  logic [PixW-1:0] test_pixel;
  logic [PixW-1:0] reference_pixel;
  logic out_valid;
  logic out_stall;
  logic [PixW-1:0] diff_pixel;
  logic [PosW-1:0] out_col;
  logic [PosW-1:0] out_row;
  logic frame_done;

  // Predictor state, mirroring the block after each accepted pixel.
  logic [SizeW-1:0] width_reg;
  logic [SizeW-1:0] height_reg;
  logic [PairW-1:0] prev_row_pair [MaxWidthDefault];
  logic [PairW-1:0] prev2_row_pair [MaxWidthDefault];
  int unsigned col_pos;
  int unsigned row_pos;
  logic [PairW-1:0] win_mid_c1, win_mid_c2, win_top_c1, win_cur_c1;

  diff_result_t expected_diffs[$];
  int error_count = 0;
  bit send_idle_on = 1'b1;
  bit recv_idle_on = 1'b1;
  bit hold_results = 1'b0;

  cross_mean_image_difference_top u_top (
    .clk             (clk),
    .rst             (rst),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .test_pixel      (test_pixel),
    .reference_pixel (reference_pixel),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .diff_pixel      (diff_pixel),
    .out_col         (out_col),
    .out_row         (out_row),
    .frame_done      (frame_done)
  );

  always #5 clk = ~clk;

  function automatic int unsigned eff_size(logic [SizeW-1:0] v, int unsigned hi);
    if (v < MinSize) return MinSize;
    if (v > hi) return hi;
    return 32'(v);
  endfunction

  function automatic int idle_cycles();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
  endfunction

  function automatic logic [SizeW-1:0] pick_size(bit for_width);
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) return SizeW'($urandom_range(MinSize, for_width ? 12 : 8));
    if (pick < 82) return SizeW'($urandom_range(0, MinSize - 1));
    if (pick < 90) return SizeW'($urandom_range(13, 40));
    if (pick < 95) return SizeW'($urandom_range(1021, 1027));
    return SizeW'($urandom_range(1028, 2047));
  endfunction

  function automatic void store_expected(diff_result_t res);
    expected_diffs = {expected_diffs, res};
  endfunction

  // Works out the result, if any, that one accepted pixel pair causes.
  function automatic void predict_mean_diff(logic [PixW-1:0] t_pix, logic [PixW-1:0] r_pix);
    int unsigned w, h, c, r, test_mean, ref_mean;
    logic [PairW-1:0] cur, above, two;
    diff_result_t res;
    w = eff_size(width_reg, MaxWidthDefault);
    h = eff_size(height_reg, MaxHeightDefault);
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
    end
    if (row_pos >= h) row_pos = 0;
    c = col_pos;
    r = row_pos;
    cur = {r_pix, t_pix};
    above = prev_row_pair[c];
    two = prev2_row_pair[c];
    if (r >= 2 && c >= 2) begin
      test_mean = (int'(win_top_c1[7:0]) + win_mid_c2[7:0] + win_mid_c1[7:0] +
                   above[7:0] + win_cur_c1[7:0]) / 5;
      ref_mean = (int'(win_top_c1[15:8]) + win_mid_c2[15:8] + win_mid_c1[15:8] +
                  above[15:8] + win_cur_c1[15:8]) / 5;
      res.diff = (test_mean > ref_mean) ? PixW'(test_mean - ref_mean) : '0;
      res.col = PosW'(c - 1);
      res.row = PosW'(r - 1);
      res.done = (r == h - 1 && c == w - 1);
      store_expected(res);
    end
    win_mid_c2 = win_mid_c1;
    win_mid_c1 = above;
    win_top_c1 = two;
    win_cur_c1 = cur;
    prev2_row_pair[c] = above;
    prev_row_pair[c] = cur;
    col_pos = c + 1;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos = r + 1;
      if (row_pos >= h) row_pos = 0;
    end
  endfunction

  task automatic send_pixel(input logic [PixW-1:0] t_pix, input logic [PixW-1:0] r_pix);
    int gap;
    gap = (send_idle_on && $urandom_range(0, 2) == 0) ? idle_cycles() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    test_pixel <= t_pix;
    reference_pixel <= r_pix;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_mean_diff(t_pix, r_pix);
  endtask

  task automatic send_random_pixel();
    logic [PixW-1:0] t_pix, r_pix;
    int unsigned mode;
    mode = $urandom_range(0, 9);
    t_pix = PixW'($urandom);
    r_pix = PixW'($urandom);
    // Closely matching images give small, often nonzero differences.
    if (mode < 3) begin
      r_pix = t_pix + PixW'($urandom_range(0, 6)) - PixW'(3);
    end else if (mode < 5) begin
      t_pix = {PixW{t_pix[0]}};
      r_pix = {PixW{r_pix[0]}};
    end
    send_pixel(t_pix, r_pix);
  endtask

  task automatic complete_frame();
    do send_random_pixel(); while (col_pos != 0 || row_pos != 0);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_diffs.size() != 0) @(posedge clk);
    // Border pixels leave no result behind, so give the pipeline time to empty.
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic put_reg(input cfg_reg_t idx, input logic [SizeW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == CFG_FRAME_WIDTH) width_reg = val;
    else height_reg = val;
  endtask

  task automatic write_sizes(input logic [SizeW-1:0] w_val, input logic [SizeW-1:0] h_val);
    wait_idle();
    // Widening mid frame would read row store entries that were never written,
    // so a wider frame is only allowed at the frame start.
    if (eff_size(w_val, MaxWidthDefault) > eff_size(width_reg, MaxWidthDefault) &&
        (col_pos != 0 || row_pos != 0)) begin
      w_val = width_reg;
    end
    put_reg(CFG_FRAME_WIDTH, w_val);
    put_reg(CFG_FRAME_HEIGHT, h_val);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_border_and_extremes();
    logic [PixW-1:0] t_pix, r_pix;
    write_sizes(11'd5, 11'd5);
    // One 5x5 frame: the top rows give the largest difference, the bottom rows
    // a negative one that clamps to zero, and the border gives nothing.
    for (int k = 0; k < 25; k++) begin
      t_pix = (k < 15) ? 8'hFF : ((k % 2) ? 8'h55 : 8'h00);
      r_pix = (k < 15) ? 8'h00 : ((k % 2) ? 8'hAA : 8'hFF);
      send_pixel(t_pix, r_pix);
    end
  endtask

  task automatic test_frame_size_limits();
    send_idle_on = 1'b0;
    recv_idle_on = 1'b0;
    // Both registers below their range: the frame is 3 by 3.
    write_sizes(11'd1, 11'd0);
    complete_frame();
    // Both registers above their range: the row runs on past column 20 until
    // the width is narrowed, which moves the position to the next row.
    write_sizes(11'h7FF, 11'h7FF);
    repeat (21) send_random_pixel();
    write_sizes(11'd3, 11'd3);
    complete_frame();
    send_idle_on = 1'b1;
    recv_idle_on = 1'b1;
  endtask

  task automatic test_mid_frame_resize();
    write_sizes(11'd8, 11'd8);
    repeat (30) send_random_pixel();
    // Narrower than the current column: the next pixel starts a new row.
    write_sizes(11'd4, 11'd8);
    repeat (10) send_random_pixel();
    // Fewer rows than the current one: the frame restarts at row 0.
    write_sizes(11'd4, 11'd5);
    repeat (8) send_random_pixel();
    // Narrower but still past the current column, and taller: the row carries on.
    write_sizes(11'd3, 11'd9);
    complete_frame();
  endtask

  task automatic test_result_backpressure();
    write_sizes(11'd12, 11'd12);
    send_idle_on = 1'b0;
    hold_results = 1'b1;
    complete_frame();
    complete_frame();
    // Pause the stream until every result has been taken.
    wait_idle();
    send_idle_on = 1'b1;
    complete_frame();
  endtask

  task automatic test_random_traffic();
    int sent;
    int phase_len;
    sent = 0;
    while (sent < RandomPixelTarget) begin
      send_idle_on = ($urandom_range(0, 3) != 0);
      recv_idle_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 2) == 0) write_sizes(pick_size(1'b1), pick_size(1'b0));
      phase_len = $urandom_range(10, 150);
      repeat (phase_len) send_random_pixel();
      sent += phase_len;
    end
  endtask

  initial begin : result_receiver
    forever begin
      if (hold_results) begin
        out_stall <= 1'b1;
        repeat (ResultHoldCycles) @(posedge clk);
        hold_results = 1'b0;
      end else if (recv_idle_on && $urandom_range(0, 2) == 0) begin
        out_stall <= 1'b1;
        repeat (idle_cycles()) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin : result_check
    diff_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_diffs.size() == 0) begin
        $error("unexpected result: diff_pixel %0d col %0d row %0d", diff_pixel, out_col,
               out_row);
        error_count++;
      end else begin
        want = expected_diffs.pop_front();
        if (diff_pixel !== want.diff) begin
          $error("diff_pixel: expected %0d, got %0d", want.diff, diff_pixel);
          error_count++;
        end
        if (out_col !== want.col) begin
          $error("out_col: expected %0d, got %0d", want.col, out_col);
          error_count++;
        end
        if (out_row !== want.row) begin
          $error("out_row: expected %0d, got %0d", want.row, out_row);
          error_count++;
        end
        if (frame_done !== want.done) begin
          $error("frame_done: expected %0d, got %0d", want.done, frame_done);
          error_count++;
        end
      end
    end
  end

  initial begin : stimulus
    rst <= 1'b1;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_FRAME_WIDTH;
    cfg_data <= '0;
    in_valid <= 1'b0;
    test_pixel <= '0;
    reference_pixel <= '0;
    width_reg = SizeW'(MaxWidthDefault);
    height_reg = SizeW'(MaxHeightDefault);
    foreach (prev_row_pair[i]) begin
      prev_row_pair[i] = '0;
      prev2_row_pair[i] = '0;
    end
    col_pos = 0;
    row_pos = 0;
    win_mid_c1 = '0;
    win_mid_c2 = '0;
    win_top_c1 = '0;
    win_cur_c1 = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_border_and_extremes();
    test_frame_size_limits();
    test_mid_frame_resize();
    test_result_backpressure();
    test_random_traffic();

    wait_idle();
    if (error_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

  initial begin : run_limit
    #10ms;
    $display("testbench NOT OK");
    $finish;
  end

endmodule
